// ----- hw/rtl/spq_pkg.sv -----
// Package for the stable priority queue: request and status codes, cell control
// struct and default sizes. No dependencies.
package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int PRIO_W           = 16;
   localparam int VALUE_W          = 32;
   localparam int OCC_W            = 5;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Operation broadcast to every cell of the row at once.
   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

// ----- hw/rtl/stable_priority_queue_unit.sv -----
// Stable sorted priority queue: top level with entry count, result register and
// the row of spq_cell slots. Depends on spq_pkg and spq_cell.
//
// Usage:
//   A request is transferred on a rising edge with start high and busy low.
//   busy is always low, so a request may be issued every cycle.
//   req_type selects insert (0) or remove (1); req_item_value and
//   req_item_prio carry the entry on insert and are ignored on remove.
//   Each request gives one result in the following cycle: rsp_valid is high for that
//   single cycle with rsp_removed_value, rsp_status and rsp_occupancy.
//   Throughput is one request per cycle: every slot
//   compares its priority against the new one and shifts in parallel.
//   Equal priorities leave in arrival order. Remove on empty reports
//   underflow; insert on full is dropped and reports full.
//   Reset empties the queue (count to zero) and clears rsp_valid; slot
//   contents are not cleared, only slots below the count are ever used.
//   The receiver cannot stall; results must be taken when rsp_valid is high.
module stable_priority_queue_unit #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_type,
   input  logic signed [spq_pkg::VALUE_W-1:0]  req_item_value,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_item_prio,
   output logic                                rsp_valid,
   output logic signed [spq_pkg::VALUE_W-1:0]  rsp_removed_value,
   output logic        [1:0]                   rsp_status,
   output logic        [spq_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [spq_pkg::VALUE_W-1:0] removed_ff, removed_in;
   spq_pkg::status_type         status_ff, status_in;

   logic                        take;
   logic                        full, empty;
   spq_pkg::cell_ctrl_type      ctrl;

   logic                              keep    [CAPACITY];
   logic signed [spq_pkg::PRIO_W-1:0] c_prio  [CAPACITY];
   logic [spq_pkg::VALUE_W-1:0]       c_value [CAPACITY];

   assign busy  = 1'b0;
   assign take  = start && !busy;
   assign full  = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      ctrl.ins   = take && (req_type == spq_pkg::REQ_INSERT) && !full;
      ctrl.rem   = take && (req_type == spq_pkg::REQ_REMOVE) && !empty;
      count_in   = count_ff;
      removed_in = '0;
      status_in  = spq_pkg::ST_INSERTED;
      rsp_valid_in = take;
      if (req_type == spq_pkg::REQ_INSERT) begin
         if (full) begin
            status_in = spq_pkg::ST_FULL;
         end else begin
            status_in = spq_pkg::ST_INSERTED;
         end
      end else begin
         if (empty) begin
            status_in = spq_pkg::ST_UNDERFLOW;
         end else begin
            status_in  = spq_pkg::ST_REMOVED;
            removed_in = c_value[0];
         end
      end
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.rem) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         removed_ff <= removed_in;
         status_ff  <= status_in;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                              l_keep;
         logic signed [spq_pkg::PRIO_W-1:0] l_prio, r_prio;
         logic [spq_pkg::VALUE_W-1:0]       l_value, r_value;

         if (gi == 0) begin : g_first
            // Front slot takes the new entry whenever it does not keep its own.
            assign l_keep  = 1'b1;
            assign l_prio  = req_item_prio;
            assign l_value = req_item_value;
         end else begin : g_mid
            assign l_keep  = keep[gi-1];
            assign l_prio  = c_prio[gi-1];
            assign l_value = c_value[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign r_prio  = '0;
            assign r_value = '0;
         end else begin : g_inner
            assign r_prio  = c_prio[gi+1];
            assign r_value = c_value[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (CNT_W'(gi) < count_ff),
            .new_prio    (req_item_prio),
            .new_value   (req_item_value),
            .left_keep   (l_keep),
            .left_prio   (l_prio),
            .left_value  (l_value),
            .right_prio  (r_prio),
            .right_value (r_value),
            .keep        (keep[gi]),
            .prio        (c_prio[gi]),
            .value       (c_value[gi])
         );
      end
   endgenerate

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_occupancy     = spq_pkg::OCC_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid)
      else $error("transfer without a result");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.rem |=> count_ff == $past(count_ff) - 1'b1)
      else $error("remove did not lower the count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::ST_FULL |-> full)
      else $error("full reported below capacity");
`endif

endmodule

// ----- hw/rtl/spq_cell.sv -----
// One slot of the sorted row: holds a priority and a data word and trades them
// with its neighbours. Depends on spq_pkg.
module spq_cell (
   input  logic                          clock,
   input  spq_pkg::cell_ctrl_type        ctrl,
   input  logic                          occupied,
   input  logic signed [spq_pkg::PRIO_W-1:0]  new_prio,
   input  logic        [spq_pkg::VALUE_W-1:0] new_value,
   input  logic                          left_keep,
   input  logic signed [spq_pkg::PRIO_W-1:0]  left_prio,
   input  logic        [spq_pkg::VALUE_W-1:0] left_value,
   input  logic signed [spq_pkg::PRIO_W-1:0]  right_prio,
   input  logic        [spq_pkg::VALUE_W-1:0] right_value,
   output logic                          keep,
   output logic signed [spq_pkg::PRIO_W-1:0]  prio,
   output logic        [spq_pkg::VALUE_W-1:0] value
);

   logic signed [spq_pkg::PRIO_W-1:0]  prio_ff, prio_in;
   logic        [spq_pkg::VALUE_W-1:0] value_ff, value_in;

   // An occupied slot at or below the new priority stays where it is.
   assign keep  = occupied && (prio_ff <= new_prio);
   assign prio  = prio_ff;
   assign value = value_ff;

   always_comb begin
      prio_in  = prio_ff;
      value_in = value_ff;
      if (ctrl.rem) begin
         prio_in  = right_prio;
         value_in = right_value;
      end else if (ctrl.ins && !keep) begin
         if (left_keep) begin
            prio_in  = new_prio;
            value_in = new_value;
         end else begin
            prio_in  = left_prio;
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      prio_ff  <= prio_in;
      value_ff <= value_in;
   end

endmodule

// ----- bench/stable_priority_queue_unit_test.sv -----
// Self-checking bench for stable_priority_queue_unit: directed and random insert and
// remove traffic, each result checked against a shadow copy of the sorted entry row.
// Depends on spq_pkg and the RTL of the queue; needs no files at run time.
module stable_priority_queue_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 1680;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic signed [VALUE_W-1:0] removed_value;
      status_type                status;
      logic [OCC_W-1:0]          occupancy;
   } outcome_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_type = REQ_INSERT;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic signed [PRIO_W-1:0]  req_item_prio = '0;
   logic                      rsp_valid;
   logic signed [VALUE_W-1:0] rsp_removed_value;
   logic [1:0]                rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;

   // Shadow of the sorted row; only entries below shadow_count are meaningful.
   logic signed [PRIO_W-1:0]  shadow_prio [QUEUE_DEPTH];
   logic signed [VALUE_W-1:0] shadow_value [QUEUE_DEPTH];
   int                        shadow_count = 0;

   outcome_type expected_outcomes [$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gaps_enabled = 1'b1;

   stable_priority_queue_unit #(
      .CAPACITY(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_item_value(req_item_value),
      .req_item_prio(req_item_prio),
      .rsp_valid(rsp_valid),
      .rsp_removed_value(rsp_removed_value),
      .rsp_status(rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("stable_priority_queue_unit test failed");
         $finish;
      end
   end

   // Apply one request to the shadow row and queue up the outcome it must give.
   function automatic void apply_to_shadow_row(input logic kind,
                                               input logic signed [VALUE_W-1:0] value,
                                               input logic signed [PRIO_W-1:0] prio);
      outcome_type outcome;
      int          pos;
      int          k;
      outcome.removed_value = '0;
      if (kind == REQ_INSERT) begin
         if (shadow_count >= QUEUE_DEPTH) begin
            outcome.status = ST_FULL;
         end else begin
            // place after every entry of lower or equal priority
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
            for (k = shadow_count; k > pos; k--) begin
               shadow_prio[k]  = shadow_prio[k-1];
               shadow_value[k] = shadow_value[k-1];
            end
            shadow_prio[pos]  = prio;
            shadow_value[pos] = value;
            shadow_count++;
            outcome.status = ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0) begin
            outcome.status = ST_UNDERFLOW;
         end else begin
            outcome.removed_value = shadow_value[0];
            for (k = 1; k < shadow_count; k++) begin
               shadow_prio[k-1]  = shadow_prio[k];
               shadow_value[k-1] = shadow_value[k];
            end
            shadow_count--;
            outcome.status = ST_REMOVED;
         end
      end
      outcome.occupancy = shadow_count[OCC_W-1:0];
      expected_outcomes.push_back(outcome);
   endfunction

   // Record each transfer first, then check any result, so a result in the same cycle as its transfer works too.
   always @(posedge clock) begin : result_check
      outcome_type due;
      if (!reset) begin
         if (start && !busy)
            apply_to_shadow_row(req_type, req_item_value, req_item_prio);
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual value %0d %s",
                        $time, rsp_removed_value,
                        $sformatf("status %0d occupancy %0d", rsp_status, rsp_occupancy));
               error_count++;
            end else begin
               due = expected_outcomes.pop_front();
               if (rsp_removed_value !== due.removed_value) begin
                  $display("%0t: removed_value expected %0d actual %0d",
                           $time, due.removed_value, rsp_removed_value);
                  error_count++;
               end
               if (rsp_status !== due.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, due.status, rsp_status);
                  error_count++;
               end
               if (rsp_occupancy !== due.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d",
                           $time, due.occupancy, rsp_occupancy);
                  error_count++;
               end
            end
         end
      end
   end

   // Drive one request and hold it until the transfer; start stays high afterwards.
   task automatic send_request(input logic kind,
                               input logic signed [VALUE_W-1:0] value,
                               input logic signed [PRIO_W-1:0] prio);
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_item_value <= value;
      req_item_prio  <= prio;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles, with noise on the idle request fields.
   task automatic hold_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start          <= 1'b0;
         req_type       <= 1'($urandom);
         req_item_value <= $urandom;
         req_item_prio  <= PRIO_W'($urandom);
      end
   endtask

   // Bursts of random length, separated by random gaps while gaps_enabled is set.
   task automatic pace_sender;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (gaps_enabled) hold_idle($urandom_range(1, 6));
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 6);
      end
   endtask

   task automatic test_underflow;
      send_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h7FFF);
      send_request(REQ_REMOVE, 32'h0000_0000, 16'h8000);
   endtask

   // Extreme values and priorities, then ties at the lowest, highest and a middle priority.
   task automatic test_fill_order;
      logic signed [PRIO_W-1:0] tie_prio [3];
      int i;
      tie_prio[0] = 16'h8000;
      tie_prio[1] = 16'h7FFF;
      tie_prio[2] = 16'sd5;
      send_request(REQ_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
      send_request(REQ_INSERT, 32'h8000_0000, 16'h8000);
      send_request(REQ_INSERT, 32'h0000_0000, 16'h0000);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
      for (i = 0; i < QUEUE_DEPTH - 4; i++) begin
         send_request(REQ_INSERT, VALUE_W'(i + 100), tie_prio[i % 3]);
         if (i % 4 == 3) hold_idle(1);
      end
   endtask

   // Would go in behind the other lowest-priority entries if it were taken.
   task automatic test_full_drop;
      send_request(REQ_INSERT, 32'h5A5A_5A5A, 16'h8000);
   endtask

   task automatic test_front_removal;
      repeat (5) send_request(REQ_REMOVE, $urandom, PRIO_W'($urandom));
   endtask

   // Segments with their own insert bias, priority spread and pacing.
   task automatic test_random_traffic;
      int sent;
      int seg_len;
      int insert_bias;
      bit narrow_prio;
      logic kind;
      logic signed [PRIO_W-1:0] prio;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         seg_len      = $urandom_range(40, 120);
         // trim the last segment to the item budget
         if (seg_len > RANDOM_ITEMS - sent) seg_len = RANDOM_ITEMS - sent;
         insert_bias  = 10 + 20 * $urandom_range(0, 4);
         narrow_prio  = 1'($urandom_range(0, 1));
         gaps_enabled = $urandom_range(0, 3) != 0;
         repeat (seg_len) begin
            kind = $urandom_range(0, 99) < insert_bias ? REQ_INSERT : REQ_REMOVE;
            case ($urandom_range(0, 15))
               0: prio = 16'h8000;
               1: prio = 16'h7FFF;
               default: prio = narrow_prio ? PRIO_W'($urandom_range(0, 3)) - 16'sd2
                                           : PRIO_W'($urandom);
            endcase
            send_request(kind, $urandom, prio);
            pace_sender();
            sent++;
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_underflow();
      test_fill_order();
      test_full_drop();
      test_front_removal();
      test_random_traffic();

      hold_idle(1);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("stable_priority_queue_unit test passed");
      else
         $display("stable_priority_queue_unit test failed");
      $finish;
   end

endmodule
